// ===== hdl/cse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants of the C string escape encoder
// Character codes, run length codes and the word passed from the
// classifier to the emitter.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_HASH      = 8'h23;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DEL       = 8'h7F;
    localparam logic [7:0] CHAR_CTRL_END  = 8'h20;

    localparam logic [7:0] CTRL_BEL = 8'h07;
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_HT  = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_VT  = 8'h0B;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_CR  = 8'h0D;

    localparam logic [7:0] LETTER_A = 8'h61;
    localparam logic [7:0] LETTER_B = 8'h62;
    localparam logic [7:0] LETTER_F = 8'h66;
    localparam logic [7:0] LETTER_N = 8'h6E;
    localparam logic [7:0] LETTER_R = 8'h72;
    localparam logic [7:0] LETTER_T = 8'h74;
    localparam logic [7:0] LETTER_V = 8'h76;

    // index of the final byte of a run
    localparam logic [1:0] RUN_LITERAL = 2'd0;
    localparam logic [1:0] RUN_PAIR    = 2'd1;
    localparam logic [1:0] RUN_OCTAL   = 2'd3;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            str_last;
    } cse_word_t;

endpackage
`default_nettype wire

// ===== hdl/cse_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_front: input classifier
// Accepts source bytes, tracks the string edge and builds the escaped run.
// ----------------------------------------------------------------------------
module cse_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              q_full,
    output logic                   q_push,
    output cse_pkg::cse_word_t     q_word
);
    import cse_pkg::*;

    logic space_mode_reg, space_mode_next;
    logic at_start_reg, at_start_next;
    logic edge_pos;
    logic use_octal;
    logic [7:0] pair_char;
    logic is_pair;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign edge_pos = at_start_reg || s_tlast;

    always_comb begin
        space_mode_next = cfg_wr_en ? cfg_wr_data : space_mode_reg;
        at_start_next   = q_push ? s_tlast : at_start_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_mode_reg <= 1'b0;
            at_start_reg   <= 1'b1;
        end else begin
            space_mode_reg <= space_mode_next;
            at_start_reg   <= at_start_next;
        end
    end

    always_comb begin
        is_pair   = 1'b1;
        pair_char = s_tdata;
        case (s_tdata)
            CTRL_BEL:       pair_char = LETTER_A;
            CTRL_BS:        pair_char = LETTER_B;
            CTRL_FF:        pair_char = LETTER_F;
            CTRL_LF:        pair_char = LETTER_N;
            CTRL_CR:        pair_char = LETTER_R;
            CTRL_HT:        pair_char = LETTER_T;
            CTRL_VT:        pair_char = LETTER_V;
            CHAR_BACKSLASH: pair_char = s_tdata;
            CHAR_DQUOTE:    pair_char = s_tdata;
            default:        is_pair = 1'b0;
        endcase
    end

    assign use_octal = (s_tdata < CHAR_CTRL_END) || (s_tdata >= CHAR_DEL)
                       || (s_tdata == CHAR_HASH)
                       || ((s_tdata == CHAR_SPACE) && space_mode_reg && edge_pos);

    always_comb begin
        q_word.str_last = s_tlast;
        q_word.bytes[0] = CHAR_BACKSLASH;
        q_word.bytes[1] = pair_char;
        q_word.bytes[2] = {5'b00110, s_tdata[5:3]};
        q_word.bytes[3] = {5'b00110, s_tdata[2:0]};
        if (is_pair) begin
            q_word.last_idx = RUN_PAIR;
        end else if (use_octal) begin
            q_word.last_idx = RUN_OCTAL;
            q_word.bytes[1] = {6'b001100, s_tdata[7:6]};
        end else begin
            q_word.last_idx = RUN_LITERAL;
            q_word.bytes[0] = s_tdata;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cse_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_queue: run queue
// Short first-in first-out buffer between the classifier and the emitter.
// ----------------------------------------------------------------------------
module cse_queue #(
    parameter int DEPTH = cse_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  cse_pkg::cse_word_t     push_word,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output cse_pkg::cse_word_t     head_word
);
    import cse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cse_word_t        store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = store[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cse_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cse_back: run emitter
// Walks the head run one byte per cycle into the output register while m_tready does not stall it.
// ----------------------------------------------------------------------------
module cse_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head_valid,
    input  cse_pkg::cse_word_t     head_word,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import cse_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       run_end_reg, run_end_next;
    logic       str_end_reg, str_end_next;
    logic       load;
    logic       at_final;

    assign load     = head_valid && (!valid_reg || m_tready);
    assign at_final = (idx_reg == head_word.last_idx);
    assign pop      = load && at_final;

    always_comb begin
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        run_end_next = run_end_reg;
        str_end_next = str_end_reg;
        if (load) begin
            valid_next   = 1'b1;
            byte_next    = head_word.bytes[idx_reg];
            run_end_next = at_final;
            str_end_next = at_final && head_word.str_last;
            idx_next     = at_final ? 2'd0 : idx_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        run_end_reg <= run_end_next;
        str_end_reg <= str_end_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = run_end_reg;
    assign m_tlast  = str_end_reg;

endmodule
`default_nettype wire

// ===== hdl/c_string_escape_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c_string_escape_encoder: C string escape encoder
// Expands each source byte into its escaped form of one to four bytes.
// ----------------------------------------------------------------------------
// One source byte enters per cycle while the run queue has room; it leaves as
// a run of one (plain byte), two (backslash and letter or byte) or four
// (backslash and three octal digits) output words, one word per cycle through
// the output register while m_tready does not stall it; the run length sets the
// sustained rate at the output port. tuser marks the final word of each run
// and tlast the final word of a string. cfg_wr_data sets the space mode:
// when 1, a space at the start or end of a string leaves as \040.
module c_string_escape_encoder #(
    parameter int QUEUE_DEPTH = cse_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // is_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] run_end
    output logic            m_tlast    // string_end
);
    import cse_pkg::*;

    cse_word_t push_word;
    cse_word_t head_word;
    logic      q_push, q_full, q_pop, q_valid;

    cse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_word      (push_word)
    );

    cse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_word  (push_word),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_word  (head_word)
    );

    cse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_word  (head_word),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_string_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("string end on a word that does not close its run");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid)
        else $error("gap inside an escape run");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("run queue popped while empty");

endmodule
`default_nettype wire
